### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`define CHK_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CHK_IMPLIES(label, clk, rst, ante, cons)
`define CHK_NEXT(label, clk, rst, ante, cons)
`define CHK_NEVER(label, clk, rst, expr)
`endif
`endif

### rtl/anxb_pkg.sv
// Types and constants for the Annex-B NAL unit splitter.
// No dependencies.
package anxb_pkg;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_END_UNIT = 2'd1;
  localparam logic [1:0] KIND_STATUS   = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       units_found;
    logic       last_of_run;
  } out_t;

  // one input byte's worth of results: zeros, then byte, then end, then status
  typedef struct packed {
    logic [2:0] zero_cnt;
    logic       has_byte;
    logic [7:0] data;
    logic       end_unit;
    logic       status;
    logic       found;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### rtl/anxb_front.sv
// Front end: start code tracking, turns each byte into a result descriptor.
// Depends on anxb_pkg.
module anxb_front import anxb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   src_valid,
  output logic   src_stall,
  input  in_t    src,
  input  qstat_t qs,
  output logic   push,
  output cmd_t   cmd
);

  logic [1:0] zero_run;
  logic       inside_unit;
  logic       unit_has_bytes;
  logic       any_unit_seen;

  logic [1:0] zero_run_next;
  logic       inside_unit_next;
  logic       unit_has_bytes_next;
  logic       any_unit_seen_next;
  logic       accept;

  assign src_stall = qs.full;
  assign accept    = src_valid && !qs.full;

  always_comb begin
    cmd                 = '0;
    cmd.data            = src.in_byte;
    zero_run_next       = zero_run;
    inside_unit_next    = inside_unit;
    unit_has_bytes_next = unit_has_bytes;
    any_unit_seen_next  = any_unit_seen;

    priority if (src.in_byte == 8'h00) begin
      if (zero_run == 2'd3) begin
        // oldest held zero is pushed out as payload
        if (inside_unit) begin
          cmd.zero_cnt        = 3'd1;
          unit_has_bytes_next = 1'b1;
        end
      end else begin
        zero_run_next = zero_run + 2'd1;
      end
    end else if (src.in_byte == 8'h01 && zero_run >= 2'd2) begin
      cmd.end_unit        = inside_unit && unit_has_bytes;
      any_unit_seen_next  = any_unit_seen | cmd.end_unit;
      inside_unit_next    = 1'b1;
      unit_has_bytes_next = 1'b0;
      zero_run_next       = 2'd0;
    end else begin
      if (inside_unit) begin
        cmd.zero_cnt        = {1'b0, zero_run};
        cmd.has_byte        = 1'b1;
        unit_has_bytes_next = 1'b1;
      end
      zero_run_next = 2'd0;
    end

    if (src.end_of_buffer) begin
      if (inside_unit_next) begin
        cmd.zero_cnt = cmd.zero_cnt + {1'b0, zero_run_next};
        if (zero_run_next != 2'd0) begin
          unit_has_bytes_next = 1'b1;
        end
      end
      if (inside_unit_next && unit_has_bytes_next) begin
        cmd.end_unit       = 1'b1;
        any_unit_seen_next = 1'b1;
      end
      cmd.status          = 1'b1;
      cmd.found           = any_unit_seen_next;
      zero_run_next       = 2'd0;
      inside_unit_next    = 1'b0;
      unit_has_bytes_next = 1'b0;
      any_unit_seen_next  = 1'b0;
    end
  end

  // bytes that yield nothing never reach the queue
  assign push = accept && (cmd.zero_cnt != 3'd0 || cmd.has_byte || cmd.end_unit || cmd.status);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run       <= 2'd0;
      inside_unit    <= 1'b0;
      unit_has_bytes <= 1'b0;
      any_unit_seen  <= 1'b0;
    end else if (accept) begin
      zero_run       <= zero_run_next;
      inside_unit    <= inside_unit_next;
      unit_has_bytes <= unit_has_bytes_next;
      any_unit_seen  <= any_unit_seen_next;
    end
  end

endmodule

### rtl/anxb_queue.sv
// Short descriptor queue between front and back ends, flip-flop storage.
// Depends on anxb_pkg.
module anxb_queue import anxb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   wdata,
  input  logic   pop,
  output cmd_t   rdata,
  output qstat_t qs
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qs.full  = (count == QCNT_W'(QDEPTH));
  assign qs.empty = (count == '0);
  assign rdata    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/anxb_back.sv
// Back end: expands the head descriptor into result words, one per cycle when
// not stalled, into the output register. Depends on anxb_pkg.
module anxb_back import anxb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   head,
  input  qstat_t qs,
  output logic   pop,
  output logic   res_valid,
  input  logic   res_stall,
  output out_t   res
);

  logic [2:0] zsent;
  logic       bsent;
  logic       esent;

  out_t r;
  logic last;
  logic step_z;
  logic step_b;
  logic step_e;
  logic go;

  assign go  = !qs.empty && (!res_valid || !res_stall);
  assign pop = go && last;

  always_comb begin
    r      = '0;
    last   = 1'b0;
    step_z = 1'b0;
    step_b = 1'b0;
    step_e = 1'b0;
    priority if (zsent != head.zero_cnt) begin
      r.kind = KIND_BYTE;
      last   = !(head.has_byte || head.end_unit || head.status) &&
               (zsent + 3'd1 == head.zero_cnt);
      step_z = 1'b1;
    end else if (head.has_byte && !bsent) begin
      r.kind     = KIND_BYTE;
      r.out_byte = head.data;
      last       = !(head.end_unit || head.status);
      step_b     = 1'b1;
    end else if (head.end_unit && !esent) begin
      r.kind = KIND_END_UNIT;
      last   = !head.status;
      step_e = 1'b1;
    end else begin
      r.kind        = KIND_STATUS;
      r.units_found = head.found;
      last          = 1'b1;
    end
    r.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zsent     <= 3'd0;
      bsent     <= 1'b0;
      esent     <= 1'b0;
      res_valid <= 1'b0;
    end else if (go) begin
      res       <= r;
      res_valid <= 1'b1;
      if (last) begin
        zsent <= 3'd0;
        bsent <= 1'b0;
        esent <= 1'b0;
      end else begin
        zsent <= zsent + {2'b00, step_z};
        bsent <= bsent | step_b;
        esent <= esent | step_e;
      end
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

### rtl/annexb_nal_splitter.sv
// Channel  Dir  Handshake             Word
// src      in   src_valid/src_stall   in_t  (in_byte, end_of_buffer)
// res      out  res_valid/res_stall   out_t (kind, out_byte, units_found, last_of_run)
//
// One byte accepted per cycle while the 4-entry descriptor queue has room.
// The back end writes one result word per cycle into the output register while
// res_stall does not hold it; a byte giving n results (1 to 6) occupies the back
// end for all of them, and its first result passes the queue and output register.
// Synchronous reset clears unit tracking, queue and output valid.
// src_stall rises only on a full queue; res_stall freezes the output register.
// Top level of the Annex-B splitter: front, queue, back. Depends on anxb_pkg.
`include "assert_macros.svh"
module annexb_nal_splitter import anxb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  in_t  src,
  output logic res_valid,
  input  logic res_stall,
  output out_t res
);

  qstat_t qs;
  logic   push;
  logic   pop;
  cmd_t   wcmd;
  cmd_t   head;

  anxb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .qs        (qs),
    .push      (push),
    .cmd       (wcmd)
  );

  anxb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wcmd),
    .pop   (pop),
    .rdata (head),
    .qs    (qs)
  );

  anxb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qs        (qs),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  `CHK_IMPLIES(a_status_last, clk, rst, res_valid && res.kind == KIND_STATUS, res.last_of_run)
  `CHK_IMPLIES(a_byte_zero, clk, rst, res_valid && res.kind != KIND_BYTE, res.out_byte == 8'h00)
  `CHK_NEVER(a_found_status, clk, rst, res_valid && res.kind != KIND_STATUS && res.units_found)
  `CHK_NEXT(a_back_moves, clk, rst, !qs.empty && !(res_valid && res_stall), res_valid)

endmodule

### tb/annexb_nal_checker.sv
// Checker for annexb_nal_splitter: watches both channels, predicts the result words
// of every accepted byte and compares them in order. Depends on anxb_pkg.
module annexb_nal_checker import anxb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  input  logic src_stall,
  input  in_t  src,
  input  logic res_valid,
  input  logic res_stall,
  input  out_t res,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] CODE_TAIL = 8'h01;

  logic [1:0] zero_run;
  logic       in_unit;
  logic       unit_bytes;
  logic       unit_seen;
  out_t       expected_words[$];
  out_t       step_words[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function void clear_tracking();
    zero_run   = 2'd0;
    in_unit    = 1'b0;
    unit_bytes = 1'b0;
    unit_seen  = 1'b0;
  endfunction

  function void put_word(logic [1:0] k, logic [7:0] b, logic f);
    out_t w;
    w.kind        = k;
    w.out_byte    = b;
    w.units_found = f;
    w.last_of_run = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  // bytes outside a unit are dropped
  function void put_payload(logic [7:0] b);
    if (in_unit) begin
      unit_bytes = 1'b1;
      put_word(KIND_BYTE, b, 1'b0);
    end
  endfunction

  function void release_zeros();
    for (int k = 0; k < zero_run; k++) put_payload(ZERO_BYTE);
    zero_run = 2'd0;
  endfunction

  function void end_unit();
    if (in_unit && unit_bytes) begin
      unit_seen = 1'b1;
      put_word(KIND_END_UNIT, 8'h00, 1'b0);
    end
    unit_bytes = 1'b0;
  endfunction

  function void predict_results(in_t w);
    int n;
    step_words.delete();
    if (w.in_byte == ZERO_BYTE) begin
      // a fourth zero pushes the oldest held one out as payload
      if (zero_run == 2'd3) put_payload(ZERO_BYTE);
      else zero_run = zero_run + 2'd1;
    end else if (w.in_byte == CODE_TAIL && zero_run >= 2'd2) begin
      zero_run = 2'd0;
      end_unit();
      in_unit    = 1'b1;
      unit_bytes = 1'b0;
    end else begin
      release_zeros();
      put_payload(w.in_byte);
    end
    if (w.end_of_buffer) begin
      release_zeros();
      end_unit();
      put_word(KIND_STATUS, 8'h00, unit_seen);
      clear_tracking();
    end
    n = step_words.size();
    if (n > 0) step_words[n-1].last_of_run = 1'b1;
    foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      clear_tracking();
      expected_words.delete();
    end else begin
      if (src_valid && !src_stall) predict_results(src);
      if (res_valid && !res_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, res);
          errors = errors + 1;
        end else begin
          want = expected_words.pop_front();
          if (res.kind != want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, res.kind);
            errors = errors + 1;
          end
          if (res.out_byte != want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     res.out_byte);
            errors = errors + 1;
          end
          if (res.units_found != want.units_found) begin
            $display("%0t: units_found expected %0d actual %0d", $time,
                     want.units_found, res.units_found);
            errors = errors + 1;
          end
          if (res.last_of_run != want.last_of_run) begin
            $display("%0t: last_of_run expected %0d actual %0d", $time,
                     want.last_of_run, res.last_of_run);
            errors = errors + 1;
          end
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

### tb/tb_annexb_nal_splitter.sv
// Testbench top for annexb_nal_splitter: drives directed and random Annex-B byte
// streams under varying back-pressure. Depends on anxb_pkg, annexb_nal_splitter and annexb_nal_checker.
module tb_annexb_nal_splitter;
  import anxb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 80;
  localparam int PHASE_BYTES = 65;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  in_t  src       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_t res;

  int   errors;
  int   pending;
  int   tx_idle_pct = 20;
  int   rx_idle_pct = 78;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt  = 0;
  in_t  burst[$];

  // opening stream: junk, both start code lengths, empty unit, 01 as payload,
  // zeros spilling into the unit, six results from one byte, buffers with no unit
  logic [8:0] opening [] = '{
    {8'hAB, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b0},
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b0},
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b0},
    {8'h01, 1'b0},
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0},
    {8'h01, 1'b0},
    {8'hC3, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b1},
    {8'h55, 1'b1},
    {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h01, 1'b1}
  };

  always #5 clk = ~clk;

  annexb_nal_splitter u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  annexb_nal_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .errors    (errors),
    .pending   (pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= LONG_HOLD;
      res_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // valid stays high from one word to the next unless an idle cycle is drawn
  task automatic send_word(input in_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src       <= w;
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  function automatic void add_to_burst(input in_t w);
    burst.insert(burst.size(), w);
  endfunction

  // biased towards zeros and 01 so that start codes turn up often
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'h00;
    if (r < 45) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random(input int target);
    int   sent;
    int   n;
    in_t  w;
    sent = 0;
    while (sent < target) begin
      burst.delete();
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          w.in_byte       = pick_byte();
          w.end_of_buffer = 1'b0;
          add_to_burst(w);
        end
      end else begin
        w.end_of_buffer = 1'b0;
        repeat ($urandom_range(0, 2)) begin
          w.in_byte = 8'($urandom_range(0, 255));
          add_to_burst(w);
        end
        repeat ($urandom_range(1, 4)) begin
          // two or three zeros make a start code; more spill into the unit
          repeat ($urandom_range(2, 5)) begin
            w.in_byte = 8'h00;
            add_to_burst(w);
          end
          w.in_byte = 8'h01;
          add_to_burst(w);
          repeat ($urandom_range(0, 10)) begin
            w.in_byte = pick_byte();
            add_to_burst(w);
          end
        end
      end
      // now and then the buffer runs on into the next one
      n = burst.size();
      burst[n-1].end_of_buffer = ($urandom_range(0, 7) != 0);
      foreach (burst[i]) send_word(burst[i]);
      sent += n;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_word(in_t'(opening[i]));
    send_random(PHASE_BYTES);

    // sender waits until every expected word is out
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    tx_idle_pct = 78;
    rx_idle_pct = 20;
    send_random(PHASE_BYTES);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 1'b1;
    send_random(PHASE_BYTES);

    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/anxb_pkg.sv
rtl/anxb_front.sv
rtl/anxb_queue.sv
rtl/anxb_back.sv
rtl/annexb_nal_splitter.sv
tb/annexb_nal_checker.sv
tb/tb_annexb_nal_splitter.sv
